@@ rtl/core/asc_pkg.sv @@
`timescale 1ns / 1ps

package asc_pkg;

    // Word memory size. It must be a power of two, so that an address wraps
    // by dropping its upper bits.
    localparam int MEM_WORDS = 16384;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    localparam int WORD_W    = 32;
    localparam int LOAD_AW   = 14;

    // Stack pointer value after reset.
    localparam logic [WORD_W-1:0] SP_RESET = 32'd10000;

    // Instruction opcodes held in the low byte of a word.
    localparam logic [7:0] OP_LDC    = 8'd0;
    localparam logic [7:0] OP_ADC    = 8'd1;
    localparam logic [7:0] OP_LDL    = 8'd2;
    localparam logic [7:0] OP_STL    = 8'd3;
    localparam logic [7:0] OP_LDNL   = 8'd4;
    localparam logic [7:0] OP_STNL   = 8'd5;
    localparam logic [7:0] OP_ADD    = 8'd6;
    localparam logic [7:0] OP_SUB    = 8'd7;
    localparam logic [7:0] OP_SHL    = 8'd8;
    localparam logic [7:0] OP_SHR    = 8'd9;
    localparam logic [7:0] OP_ADJ    = 8'd10;
    localparam logic [7:0] OP_A2SP   = 8'd11;
    localparam logic [7:0] OP_SP2A   = 8'd12;
    localparam logic [7:0] OP_CALL   = 8'd13;
    localparam logic [7:0] OP_RETURN = 8'd14;
    localparam logic [7:0] OP_BRZ    = 8'd15;
    localparam logic [7:0] OP_BRLZ   = 8'd16;
    localparam logic [7:0] OP_BR     = 8'd17;
    localparam logic [7:0] OP_HALT   = 8'd18;

    // Values of the func field.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MEM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     func;
        logic [LOAD_AW-1:0]       load_address;
        logic signed [WORD_W-1:0] load_data;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_W-1:0] reg_a;
        logic signed [WORD_W-1:0] reg_b;
        logic signed [WORD_W-1:0] stack_pointer;
        logic signed [WORD_W-1:0] program_counter;
        logic                     halted;
    } t_out_beat;

endpackage

@@ rtl/core/accumulator_stack_cpu_step_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_beat  (t_in_beat)
// output    out        o_out_valid / i_out_ready o_out_beat (t_out_beat)
// config    in         i_cfg_we                  i_cfg_wdata (14 bits)
//
// A step beat passes accept with fetch, execute and result; ldl and ldnl add
// a memory state, whose data read is a second pass through the single RAM
// read port. A load beat, and a step while halted, go from accept to result.
// After reset the word memory is cleared one word a cycle, all MEM_WORDS words
// (16384), while no input beat is accepted; config writes are taken.
// A result waiting on the output does not stop the next beat from being
// accepted; only its own result then waits until the output register frees.
module accumulator_stack_cpu_step_unit
    import asc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_beat   o_out_beat,
    input  logic        i_cfg_we,
    input  logic [13:0] i_cfg_wdata
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_WORDS - 1);

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_a, n_a;
    logic [WORD_W-1:0]   r_b, n_b;
    logic [WORD_W-1:0]   r_sp, n_sp;
    logic [WORD_W-1:0]   r_pc, n_pc;
    logic                r_halt, n_halt;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_out_valid, n_out_valid;
    t_out_beat           r_out_beat, n_out_beat;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;

    logic [7:0]          opcode;
    logic [WORD_W-1:0]   operand;
    logic [WORD_W-1:0]   pc_inc;
    logic [WORD_W-1:0]   sp_sum;
    logic [WORD_W-1:0]   a_sum;
    logic [ADDR_W-1:0]   load_addr;

    // Fields of the fetched word and the addresses derived from it.
    assign opcode    = mem_rdata[7:0];
    assign operand   = {{8{mem_rdata[WORD_W-1]}}, mem_rdata[WORD_W-1:8]};
    assign pc_inc    = r_pc + 32'd1;
    assign sp_sum    = r_sp + operand;
    assign a_sum     = r_a + operand;
    assign load_addr = ADDR_W'(i_in_beat.load_address);

    asc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_word_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // State and register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_a         <= '0;
            r_b         <= '0;
            r_sp        <= SP_RESET;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_b         <= n_b;
            r_sp        <= n_sp;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // The output payload register needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    // Sequencer, instruction execution and memory port control.
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_sp        = r_sp;
        n_pc        = r_pc;
        n_halt      = r_halt;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = r_pc[ADDR_W-1:0];

        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_beat.func == FUNC_LOAD) begin
                        mem_we    = 1'b1;
                        mem_waddr = load_addr;
                        mem_wdata = i_in_beat.load_data;
                        n_state   = ST_DONE;
                    end else if (r_halt) begin
                        n_state = ST_DONE;
                    end else begin
                        // The fetch address is the default read address.
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_pc    = pc_inc;
                n_state = ST_DONE;
                case (opcode)
                    OP_LDC: begin
                        n_b = r_a;
                        n_a = operand;
                    end
                    OP_ADC: n_a = a_sum;
                    OP_LDL: begin
                        n_b       = r_a;
                        mem_raddr = sp_sum[ADDR_W-1:0];
                        n_state   = ST_MEM;
                    end
                    OP_STL: begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_sum[ADDR_W-1:0];
                        mem_wdata = r_a;
                        n_a       = r_b;
                    end
                    OP_LDNL: begin
                        mem_raddr = a_sum[ADDR_W-1:0];
                        n_state   = ST_MEM;
                    end
                    OP_STNL: begin
                        mem_we    = 1'b1;
                        mem_waddr = a_sum[ADDR_W-1:0];
                        mem_wdata = r_b;
                    end
                    OP_ADD: n_a = r_b + r_a;
                    OP_SUB: n_a = r_b - r_a;
                    OP_SHL: n_a = r_b << r_a[4:0];
                    OP_SHR: n_a = WORD_W'($signed(r_b) >>> r_a[4:0]);
                    OP_ADJ: n_sp = sp_sum;
                    OP_A2SP: begin
                        n_sp = r_a;
                        n_a  = r_b;
                    end
                    OP_SP2A: begin
                        n_b = r_a;
                        n_a = r_sp;
                    end
                    OP_CALL: begin
                        n_b  = r_a;
                        n_a  = pc_inc;
                        n_pc = pc_inc + operand;
                    end
                    OP_RETURN: begin
                        n_pc = r_a;
                        n_a  = r_b;
                    end
                    OP_BRZ: begin
                        if (r_a == '0) begin
                            n_pc = pc_inc + operand;
                        end
                    end
                    OP_BRLZ: begin
                        if (r_a[WORD_W-1]) begin
                            n_pc = pc_inc + operand;
                        end
                    end
                    OP_BR:   n_pc   = pc_inc + operand;
                    OP_HALT: n_halt = 1'b1;
                    default: begin
                        // Unknown opcodes only advance pc.
                    end
                endcase
            end
            ST_MEM: begin
                n_a     = mem_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_beat.reg_a           = r_a;
                    n_out_beat.reg_b           = r_b;
                    n_out_beat.stack_pointer   = r_sp;
                    n_out_beat.program_counter = r_pc;
                    n_out_beat.halted          = r_halt;
                    n_state                    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // A config write reloads the stack pointer at once.
        if (i_cfg_we) begin
            n_sp = WORD_W'(i_cfg_wdata);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

@@ rtl/core/asc_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module asc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/asc_checker.sv @@
`timescale 1ns / 1ps

module asc_checker
    import asc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_beat   o_out_beat
);

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_beat))
        else $error("stalled result beat changed");

    // The memory clear keeps the input closed right after reset.
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input accepted during the memory clear");

    // Every accepted beat takes the block out of idle, so input ready drops.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready in the cycle after an accepted beat");

    // Once halted is shown it stays set until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.halted |=> o_out_beat.halted)
        else $error("halted flag cleared without reset");

endmodule

bind accumulator_stack_cpu_step_unit asc_checker u_asc_checker (.*);
